[sv/slo2_pkg.sv]
// Package for the two-component linear ODE stepper: widths, codes, reset values and the ALU control type.
package slo2_pkg;
  localparam int WORD_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 32;
  localparam int FIELD_W = 48;
  localparam int STEP_W = 47;

  localparam logic [1:0] METH_EULER = 2'd0;
  localparam logic [1:0] METH_TRAP = 2'd1;
  localparam logic [1:0] METH_IMPL = 2'd2;

  localparam logic [2:0] REG_C00 = 3'd0;
  localparam logic [2:0] REG_C01 = 3'd1;
  localparam logic [2:0] REG_C10 = 3'd2;
  localparam logic [2:0] REG_C11 = 3'd3;
  localparam logic [2:0] REG_METHOD = 3'd4;
  localparam logic [2:0] REG_THRESH = 3'd5;

  localparam logic FUNC_LOAD = 1'b0;

  // ALU operation codes
  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_ADD = 2'd1;
  localparam logic [1:0] ALU_SUB = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  localparam logic signed [63:0] RST_C00 = 64'sd4286377361408;
  localparam logic signed [63:0] RST_C01 = 64'sd8581344657408;
  localparam logic signed [63:0] RST_C10 = -64'sd4290672328704;
  localparam logic signed [63:0] RST_C11 = -64'sd8585639624704;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;
endpackage

[sv/stiff_linear_ode2_stepper_unit.sv]
// Top level of the two-component linear ODE stepper.
// One transfer on s_axis either loads the state (func 0) or advances it by one
// step of length h (func 1) with explicit Euler, trapezoidal or implicit Euler,
// chosen by the method register; exactly one result transfer follows on
// m_axis. All arithmetic is saturating signed fixed point done by one shared
// ALU under a microcoded sequencer, so s_axis_tready is low while an item runs.
// A load registers the new state and offers it on m_axis directly. Each
// microcode op passes an issue state and then waits for the ALU to finish; a
// divide runs in the bit-serial divider. A singular system skips the Cramer
// numerators and the two determinant divisions. The result stays offered on
// m_axis until it is taken.
module stiff_linear_ode2_stepper_unit #(
  parameter int WORD_BITS = slo2_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = slo2_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // init_u [47:0], init_v [95:48], step_size [142:96], zero pad
  input  logic [143:0]  s_axis_tdata,
  input  logic          s_axis_tuser,    // func
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_u [47:0], out_v [95:48]
  output logic [95:0]   m_axis_tdata,
  output logic          m_axis_tuser     // singular
);
  import slo2_pkg::*;

  localparam int W = WORD_BITS;
  typedef logic signed [W-1:0] word_t;
  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE = (FRAC_BITS >= W - 1) ? WMAX : word_t'(64'd1 << FRAC_BITS);

  // scratch register file indexes
  localparam int NR = 16;
  localparam logic [3:0] R_U = 4'd0, R_V = 4'd1, R_H = 4'd2, R_C = 4'd3;
  localparam logic [3:0] R_FU = 4'd4, R_FV = 4'd5, R_T = 4'd6, R_RU = 4'd7;
  localparam logic [3:0] R_RV = 4'd8, R_L00 = 4'd9, R_L01 = 4'd10, R_L10 = 4'd11;
  localparam logic [3:0] R_L11 = 4'd12, R_DET = 4'd13, R_ONE = 4'd14, R_ZERO = 4'd15;
  // operand codes beyond the file select coefficients
  localparam logic [4:0] O_C00 = 5'd16, O_C01 = 5'd17, O_C10 = 5'd18, O_C11 = 5'd19;

  function automatic word_t sat_in(input logic [63:0] x);
    logic signed [FIELD_W-1:0] f;
    f = x[FIELD_W-1:0];
    if (W >= FIELD_W) sat_in = word_t'(f);
    else if (64'(f) > 64'(WMAX) && !f[FIELD_W-1]) sat_in = WMAX;
    else if ($signed(64'(f)) < $signed(64'(WMIN))) sat_in = WMIN;
    else sat_in = word_t'(f);
  endfunction

  function automatic word_t sat_h(input logic [STEP_W-1:0] x);
    if ({1'b0, x} > (STEP_W+1)'(WMAX)) sat_h = WMAX;
    else sat_h = word_t'(x);
  endfunction

  // configuration
  word_t coef_q [4];
  logic [1:0] method_q;
  logic [STEP_W-1:0] thr_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= sat_in(64'(RST_C00));
      coef_q[1] <= sat_in(64'(RST_C01));
      coef_q[2] <= sat_in(64'(RST_C10));
      coef_q[3] <= sat_in(64'(RST_C11));
      method_q <= METH_IMPL;
      thr_q <= STEP_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_C00: coef_q[0] <= sat_in(cfg_data_i);
        REG_C01: coef_q[1] <= sat_in(cfg_data_i);
        REG_C10: coef_q[2] <= sat_in(cfg_data_i);
        REG_C11: coef_q[3] <= sat_in(cfg_data_i);
        REG_METHOD: method_q <= cfg_data_i[1:0];
        REG_THRESH: thr_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // microcode: op, dest, srcA, srcB
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
  } uop_t;

  // program offsets
  localparam logic [4:0] P_F = 5'd0;    // slopes, 6 ops
  localparam logic [4:0] P_EU = 5'd6;   // explicit, 4 ops
  localparam logic [4:0] P_TR = 5'd10;  // trapezoidal rhs, 4 ops
  localparam logic [4:0] P_L = 5'd14;   // matrix & det, 11 ops

  function automatic uop_t ucode(input logic [4:0] pc);
    case (pc)
      5'd0: ucode = '{ALU_MUL, R_FU, O_C00, 5'(R_U)};
      5'd1: ucode = '{ALU_MUL, R_T, O_C01, 5'(R_V)};
      5'd2: ucode = '{ALU_ADD, R_FU, 5'(R_FU), 5'(R_T)};
      5'd3: ucode = '{ALU_MUL, R_FV, O_C10, 5'(R_U)};
      5'd4: ucode = '{ALU_MUL, R_T, O_C11, 5'(R_V)};
      5'd5: ucode = '{ALU_ADD, R_FV, 5'(R_FV), 5'(R_T)};
      5'd6: ucode = '{ALU_MUL, R_T, 5'(R_H), 5'(R_FU)};
      5'd7: ucode = '{ALU_ADD, R_U, 5'(R_U), 5'(R_T)};
      5'd8: ucode = '{ALU_MUL, R_T, 5'(R_H), 5'(R_FV)};
      5'd9: ucode = '{ALU_ADD, R_V, 5'(R_V), 5'(R_T)};
      5'd10: ucode = '{ALU_MUL, R_T, 5'(R_C), 5'(R_FU)};
      5'd11: ucode = '{ALU_ADD, R_RU, 5'(R_U), 5'(R_T)};
      5'd12: ucode = '{ALU_MUL, R_T, 5'(R_C), 5'(R_FV)};
      5'd13: ucode = '{ALU_ADD, R_RV, 5'(R_V), 5'(R_T)};
      5'd14: ucode = '{ALU_MUL, R_T, 5'(R_C), O_C00};
      5'd15: ucode = '{ALU_SUB, R_L00, 5'(R_ONE), 5'(R_T)};
      5'd16: ucode = '{ALU_MUL, R_T, 5'(R_C), O_C01};
      5'd17: ucode = '{ALU_SUB, R_L01, 5'(R_ZERO), 5'(R_T)};
      5'd18: ucode = '{ALU_MUL, R_T, 5'(R_C), O_C10};
      5'd19: ucode = '{ALU_SUB, R_L10, 5'(R_ZERO), 5'(R_T)};
      5'd20: ucode = '{ALU_MUL, R_T, 5'(R_C), O_C11};
      5'd21: ucode = '{ALU_SUB, R_L11, 5'(R_ONE), 5'(R_T)};
      5'd22: ucode = '{ALU_MUL, R_DET, 5'(R_L00), 5'(R_L11)};
      5'd23: ucode = '{ALU_MUL, R_T, 5'(R_L01), 5'(R_L10)};
      5'd24: ucode = '{ALU_SUB, R_DET, 5'(R_DET), 5'(R_T)};
      // Cramer numerators and quotients (after singular check)
      5'd25: ucode = '{ALU_MUL, R_FU, 5'(R_L11), 5'(R_RU)};
      5'd26: ucode = '{ALU_MUL, R_T, 5'(R_L01), 5'(R_RV)};
      5'd27: ucode = '{ALU_SUB, R_FU, 5'(R_FU), 5'(R_T)};
      5'd28: ucode = '{ALU_MUL, R_FV, 5'(R_L00), 5'(R_RV)};
      5'd29: ucode = '{ALU_MUL, R_T, 5'(R_L10), 5'(R_RU)};
      5'd30: ucode = '{ALU_SUB, R_FV, 5'(R_FV), 5'(R_T)};
      5'd31: ucode = '{ALU_DIV, R_U, 5'(R_FU), 5'(R_DET)};
      default: ucode = '{ALU_ADD, R_T, 5'(R_ZERO), 5'(R_ZERO)};
    endcase
  endfunction

  localparam logic [4:0] PC_DIV_U = 5'd31;
  localparam logic [4:0] PC_LAST_L = 5'd24;

  localparam logic [2:0] S_IDLE = 3'd0, S_ISSUE = 3'd1, S_WAIT = 3'd2;
  localparam logic [2:0] S_DIVV = 3'd3, S_WAITV = 3'd4, S_OUT = 3'd5;

  logic [2:0] state_q;
  logic [4:0] pc_q;
  logic sing_q;
  word_t rf_q [NR];

  uop_t uop;
  assign uop = ucode(pc_q);

  function automatic word_t rd(input logic [4:0] s, input word_t rf [NR], input word_t cf [4]);
    if (s[4]) rd = cf[s[1:0]];
    else rd = rf[s[3:0]];
  endfunction

  alu_ctl_t ctl;
  word_t opa, opb, alu_res;
  logic alu_done;
  logic div_v;
  assign div_v = (state_q == S_DIVV);
  assign ctl.start = (state_q == S_ISSUE) || div_v;
  assign ctl.op = div_v ? ALU_DIV : uop.op;
  assign opa = div_v ? rf_q[R_FV] : rd(uop.sa, rf_q, coef_q);
  assign opb = div_v ? rf_q[R_DET] : rd(uop.sb, rf_q, coef_q);

  slo2_alu #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i, .rst_ni, .ctl_i(ctl), .a_i(opa), .b_i(opb),
    .done_o(alu_done), .res_o(alu_res)
  );

  // |det| vs threshold, checked on the value just written
  word_t det_new;
  logic [W-1:0] det_mag;
  logic det_sing;
  assign det_new = alu_res;
  assign det_mag = det_new[W-1] ? W'(-det_new) : W'(det_new);
  assign det_sing = (det_new == '0) || ({1'b0, det_mag} < (W+1)'(thr_q));

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      sing_q <= 1'b0;
      rf_q[R_U] <= '0;
      rf_q[R_V] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sing_q <= 1'b0;
            rf_q[R_ONE] <= ONE;
            rf_q[R_ZERO] <= '0;
            if (s_axis_tuser == FUNC_LOAD) begin
              rf_q[R_U] <= sat_in(64'(s_axis_tdata[47:0]));
              rf_q[R_V] <= sat_in(64'(s_axis_tdata[95:48]));
              state_q <= S_OUT;
            end else begin
              rf_q[R_H] <= sat_h(s_axis_tdata[142:96]);
              rf_q[R_C] <= (method_q == METH_TRAP) ? (sat_h(s_axis_tdata[142:96]) >>> 1)
                                                   : sat_h(s_axis_tdata[142:96]);
              rf_q[R_RU] <= rf_q[R_U];
              rf_q[R_RV] <= rf_q[R_V];
              pc_q <= P_F;
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            rf_q[uop.dst] <= alu_res;
            if (pc_q == P_EU - 5'd1) begin
              // slopes done: branch to the selected method
              state_q <= S_ISSUE;
              if (method_q == METH_EULER) pc_q <= P_EU;
              else if (method_q == METH_TRAP) pc_q <= P_TR;
              else pc_q <= P_L;
            end else if (pc_q == P_TR - 5'd1) begin
              state_q <= S_OUT;
            end else if (pc_q == PC_LAST_L && det_sing) begin
              sing_q <= 1'b1;
              rf_q[R_U] <= '0;
              rf_q[R_V] <= '0;
              state_q <= S_OUT;
            end else if (pc_q == PC_DIV_U) begin
              state_q <= S_DIVV;
            end else begin
              pc_q <= pc_q + 5'd1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_DIVV: state_q <= S_WAITV;
        S_WAITV: begin
          if (alu_done) begin
            rf_q[R_V] <= alu_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  function automatic logic [FIELD_W-1:0] sat_out(input word_t x);
    if (W <= FIELD_W) sat_out = FIELD_W'(x);
    else if ($signed(x) > $signed(word_t'(64'((64'd1 << (FIELD_W-1)) - 1))))
      sat_out = {1'b0, {(FIELD_W-1){1'b1}}};
    else if ($signed(x) < -$signed(word_t'(64'(64'd1 << (FIELD_W-1)))))
      sat_out = {1'b1, {(FIELD_W-1){1'b0}}};
    else sat_out = FIELD_W'(x);
  endfunction

  assign m_axis_tdata = {sat_out(rf_q[R_V]), sat_out(rf_q[R_U])};
  assign m_axis_tuser = sing_q;
endmodule

[sv/slo2_alu.sv]
// Shared saturating multiply / add / subtract / divide unit, multi-cycle.
module slo2_alu #(
  parameter int WORD_BITS = slo2_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = slo2_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slo2_pkg::alu_ctl_t          ctl_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o
);
  import slo2_pkg::*;

  localparam int W = WORD_BITS;
  localparam int HW = (W + 1) / 2;
  localparam int PW = 2 * W;
  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q;
  logic neg_q;
  logic [W-1:0] ma_q, mb_q;
  logic [PW-1:0] acc_q, acc_d;
  logic [NW-1:0] num_q, num_d;
  logic [W-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [W-1:0] res_q, res_d;
  logic done_q;

  logic [W-1:0] ma, mb;
  assign ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb = b_i[W-1] ? W'(-b_i) : W'(b_i);

  // half-width partial product: a * b[half]
  logic [HW-1:0] bhalf;
  logic [W+HW-1:0] pp;
  assign bhalf = (state_q == S_MUL0) ? mb_q[HW-1:0] : HW'(mb_q >> HW);
  assign pp = ma_q * bhalf;

  logic [PW-1:0] sh;
  assign sh = acc_q >> FRAC_BITS;

  logic signed [W:0] sum;
  assign sum = (op_q == ALU_SUB) ? ($signed({a_i[W-1], a_i}) - $signed({b_i[W-1], b_i}))
                                  : ($signed({a_i[W-1], a_i}) + $signed({b_i[W-1], b_i}));

  // remainder stays below the divisor magnitude, so W bits hold it
  logic [W:0] rsh;
  logic [W+1:0] rtry;
  assign rsh = {rem_q, num_q[NW-1]};
  assign rtry = {1'b0, rsh} - {2'b0, mb_q};

  function automatic logic [W-1:0] from_mag(input logic neg, input logic [PW-1:0] m);
    logic ovf;
    ovf = (m > PW'(WMAX) + PW'(neg));
    if (ovf) from_mag = neg ? WMIN : WMAX;
    else from_mag = neg ? W'(-m) : m[W-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    acc_d = acc_q;
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          case (ctl_i.op)
            ALU_MUL: state_d = S_MUL0;
            ALU_DIV: begin
              state_d = S_DIV;
              num_d = NW'(ma) << FRAC_BITS;
              rem_d = '0;
              acc_d = '0;
              cnt_d = CW'(NW);
            end
            default: state_d = S_FIN;
          endcase
          if (ctl_i.op == ALU_MUL) acc_d = '0;
        end
      end
      S_MUL0: begin
        acc_d = PW'(pp);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        acc_d = acc_q + (PW'(pp) << HW);
        state_d = S_FIN;
      end
      S_DIV: begin
        num_d = num_q << 1;
        if (!rtry[W+1]) begin
          rem_d = rtry[W-1:0];
          acc_d = {acc_q[PW-2:0], 1'b1};
        end else begin
          rem_d = rsh[W-1:0];
          acc_d = {acc_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
        case (op_q)
          ALU_MUL: res_d = from_mag(neg_q, sh);
          ALU_DIV: res_d = from_mag(neg_q, acc_q);
          default: begin
            if (sum[W] != sum[W-1]) res_d = sum[W] ? WMIN : WMAX;
            else res_d = sum[W-1:0];
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
      op_q <= ALU_MUL;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == S_FIN);
      if (state_q == S_IDLE && ctl_i.start) op_q <= ctl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && ctl_i.start) begin
      ma_q <= ma;
      mb_q <= mb;
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end
    acc_q <= acc_d;
    num_q <= num_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;
endmodule
